[src/rlfb_pkg.sv]
// ----------------------------------------------------------------------------
// rlfb_pkg
// Shared types, codes and constants for the RGB LED fade and blink controller.
// ----------------------------------------------------------------------------
package rlfb_pkg;

  localparam int KIND_W    = 3;
  localparam int COLOR_W   = 8;
  localparam int STEPS_W   = 8;
  localparam int SECS_W    = 12;
  localparam int PIDX_W    = 4;
  localparam int FIVL_W    = 10;
  localparam int HALF_W    = 16;
  localparam int ELAPSED_W = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int NUM_CHAN  = 3;
  localparam int CHAN_W    = 2;
  localparam int DIV_BITS  = 16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PRESET = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FADE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BLINK  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_OFF    = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FADE_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF    = 1'b1;

  localparam logic [FIVL_W-1:0]    FADE_INTERVAL_RST = 10'd20;
  localparam logic [FIVL_W-1:0]    FADE_INTERVAL_MAX = 10'd1000;
  localparam logic [HALF_W-1:0]    BLINK_HALF_RST    = 16'd1000;
  localparam logic [SECS_W-1:0]    BLINK_SECS_MAX    = 12'd3600;
  localparam logic [SECS_W-1:0]    PHASE_SAT         = 12'hFFF;
  localparam logic [ELAPSED_W-1:0] ELAPSED_SAT       = 16'hFFFF;
  localparam logic [COLOR_W-1:0]   LEVEL_MAX         = 8'd255;
  localparam logic [PIDX_W-1:0]    PRESET_LAST       = 4'd9;

  typedef logic [COLOR_W-1:0] level_t;
  typedef level_t [NUM_CHAN-1:0] rgb_t;   // [0] red, [1] green, [2] blue

  // controller -> datapath
  typedef struct packed {
    logic              cap;        // latch accepted word
    logic              exec;       // run command, or fade timing on a tick
    logic              mul;        // form (tgt-cur)*step for chan
    logic              div_start;
    logic              apply;      // write faded level of chan
    logic              blink;
    logic              out_load;
    logic [CHAN_W-1:0] chan;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic fade_fire;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic rgb_t preset_color(input logic [PIDX_W-1:0] idx);
    rgb_t c;
    c = '0;
    unique case (idx)
      4'd0:    c = {8'd0,   8'd0,   8'd255};
      4'd1:    c = {8'd0,   8'd255, 8'd0};
      4'd2:    c = {8'd255, 8'd0,   8'd0};
      4'd3:    c = {8'd255, 8'd255, 8'd255};
      4'd4:    c = {8'd0,   8'd255, 8'd255};
      4'd5:    c = {8'd255, 8'd255, 8'd0};
      4'd6:    c = {8'd255, 8'd0,   8'd255};
      4'd7:    c = {8'd0,   8'd165, 8'd255};
      4'd8:    c = {8'd180, 8'd105, 8'd255};
      4'd9:    c = {8'd128, 8'd0,   8'd128};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

[src/rlfb_item_if.sv]
// ----------------------------------------------------------------------------
// rlfb_item_if
// Input word channel: tick or command with its operands.
// ----------------------------------------------------------------------------
interface rlfb_item_if import rlfb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [COLOR_W-1:0]  red_in;
  logic [COLOR_W-1:0]  green_in;
  logic [COLOR_W-1:0]  blue_in;
  logic [STEPS_W-1:0]  fade_steps;
  logic [SECS_W-1:0]   blink_seconds;
  logic [PIDX_W-1:0]   preset_index;

  modport source (output valid, kind, red_in, green_in, blue_in, fade_steps,
                  blink_seconds, preset_index, input ready);
  modport sink (input valid, kind, red_in, green_in, blue_in, fade_steps,
                blink_seconds, preset_index, output ready);
endinterface

[src/rlfb_result_if.sv]
// ----------------------------------------------------------------------------
// rlfb_result_if
// Result word channel: LED levels and status flags.
// ----------------------------------------------------------------------------
interface rlfb_result_if import rlfb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red_out;
  logic [COLOR_W-1:0] green_out;
  logic [COLOR_W-1:0] blue_out;
  logic               fade_active;
  logic               blink_active;
  logic               preset_error;

  modport source (output valid, red_out, green_out, blue_out, fade_active,
                  blink_active, preset_error, input ready);
  modport sink (input valid, red_out, green_out, blue_out, fade_active,
                blink_active, preset_error, output ready);
endinterface

[src/rlfb_cfg_if.sv]
// ----------------------------------------------------------------------------
// rlfb_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface rlfb_cfg_if import rlfb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/rgb_led_fade_blink_controller.sv]
// ----------------------------------------------------------------------------
// rgb_led_fade_blink_controller
// A command runs its exec step and then loads the result. A tick with no fade
// step runs the blink step before the result. A tick that takes a fade step
// first runs each of the three channels in turn through the one divider. One word
// at a time: the next word is taken once the result is loaded.
// Reset: synchronous; colors black, fade and blink idle, registers 20 / 1000.
// ----------------------------------------------------------------------------
module rgb_led_fade_blink_controller import rlfb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  rlfb_item_if.sink     item,
  rlfb_result_if.source result,
  rlfb_cfg_if.sink      cfg
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign item.ready = in_ready;

  rlfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rlfb_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .kind          (item.kind),
    .red_in        (item.red_in),
    .green_in      (item.green_in),
    .blue_in       (item.blue_in),
    .fade_steps    (item.fade_steps),
    .blink_seconds (item.blink_seconds),
    .preset_index  (item.preset_index),
    .cfg           (cfg),
    .result        (result)
  );

endmodule

[src/rlfb_div.sv]
// ----------------------------------------------------------------------------
// rlfb_div
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module rlfb_div import rlfb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [STEPS_W-1:0]  divisor,
  output logic                done,
  output logic [DIV_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_BITS - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [STEPS_W-1:0] rem;
  logic [DIV_BITS-1:0] quo;   // dividend shifts out the top, quotient in the bottom

  logic [STEPS_W:0]   rem_sh;
  logic [STEPS_W:0]   rem_sub;
  logic               ge;

  assign rem_sh  = {rem, quo[DIV_BITS-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CNT_LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= ge ? rem_sub[STEPS_W-1:0] : rem_sh[STEPS_W-1:0];
        quo <= {quo[DIV_BITS-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

[src/rlfb_datapath.sv]
// ----------------------------------------------------------------------------
// rlfb_datapath
// Color, fade and blink state, config registers and the result register.
// ----------------------------------------------------------------------------
module rlfb_datapath import rlfb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  input  logic [KIND_W-1:0]  kind,
  input  logic [COLOR_W-1:0] red_in,
  input  logic [COLOR_W-1:0] green_in,
  input  logic [COLOR_W-1:0] blue_in,
  input  logic [STEPS_W-1:0] fade_steps,
  input  logic [SECS_W-1:0]  blink_seconds,
  input  logic [PIDX_W-1:0]  preset_index,
  rlfb_cfg_if.sink           cfg,
  rlfb_result_if.source      result
);

  // config
  logic [FIVL_W-1:0] fade_interval;
  logic [HALF_W-1:0] blink_half;

  // latched word
  logic [KIND_W-1:0]  kind_q;
  rgb_t               rgb_q;
  logic [STEPS_W-1:0] steps_q;
  logic [SECS_W-1:0]  secs_q;
  logic [PIDX_W-1:0]  pidx_q;

  // state
  rgb_t                cur;
  rgb_t                tgt;
  logic [STEPS_W-1:0]  fade_count;
  logic [STEPS_W-1:0]  fade_total;
  logic [ELAPSED_W-1:0] fade_elapsed;
  logic [SECS_W-1:0]   blink_limit;
  logic [SECS_W-1:0]   blink_phase;
  logic                blink_on;
  logic [ELAPSED_W-1:0] blink_elapsed;
  logic                perr;

  // fade step product
  logic                prod_neg;
  logic [DIV_BITS-1:0] prod_mag;

  logic                 div_done;
  logic [DIV_BITS-1:0]  quo;

  rlfb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_mag),
    .divisor  (fade_total),
    .done     (div_done),
    .quotient (quo)
  );

  // ---- fade timing ----
  logic [FIVL_W-1:0]    fade_lim;
  logic [ELAPSED_W-1:0] fade_el_inc;
  logic                 fade_run;
  logic                 fade_due;

  // fade_due is seen by the controller while the tick executes
  always_comb begin
    fade_lim = fade_interval;
    if (fade_lim == '0) fade_lim = FIVL_W'(1);
    if (fade_lim > FADE_INTERVAL_MAX) fade_lim = FADE_INTERVAL_MAX;
    fade_el_inc = (fade_elapsed == ELAPSED_SAT) ? fade_elapsed : fade_elapsed + 1'b1;
    fade_run    = fade_count < fade_total;
    fade_due    = fade_run && (fade_el_inc >= ELAPSED_W'(fade_lim));
  end

  // ---- fade product and apply ----
  logic signed [COLOR_W:0]     diff;
  logic signed [2*COLOR_W+1:0] prod;
  logic [2*COLOR_W+1:0]        prod_abs;
  logic signed [COLOR_W+1:0]   q_s;
  logic signed [COLOR_W+1:0]   v;
  level_t                      v_sat;

  always_comb begin
    diff     = $signed({1'b0, tgt[cmd.chan]}) - $signed({1'b0, cur[cmd.chan]});
    prod     = diff * $signed({1'b0, fade_count});
    prod_abs = prod[2*COLOR_W+1] ? -prod : prod;
    q_s      = prod_neg ? -$signed({2'b00, quo[COLOR_W-1:0]})
                        :  $signed({2'b00, quo[COLOR_W-1:0]});
    v        = $signed({2'b00, cur[cmd.chan]}) + q_s;
    if (v[COLOR_W+1])   v_sat = '0;
    else if (v[COLOR_W]) v_sat = LEVEL_MAX;
    else                 v_sat = v[COLOR_W-1:0];
  end

  // ---- blink timing ----
  logic [HALF_W-1:0]    blink_lim;
  logic [ELAPSED_W-1:0] blink_el_inc;
  logic                 blink_on_new;
  logic [SECS_W-1:0]    blink_phase_new;

  always_comb begin
    blink_lim    = (blink_half == '0) ? HALF_W'(1) : blink_half;
    blink_el_inc = (blink_elapsed == ELAPSED_SAT) ? blink_elapsed : blink_elapsed + 1'b1;
    blink_on_new = ~blink_on;
    blink_phase_new = blink_phase;
    if (blink_on_new && blink_phase != PHASE_SAT) blink_phase_new = blink_phase + 1'b1;
  end

  // ---- command operands ----
  logic [STEPS_W-1:0] steps_sat;
  logic [SECS_W-1:0]  secs_sat;

  always_comb begin
    steps_sat = (steps_q == '0) ? STEPS_W'(1) : steps_q;
    secs_sat  = secs_q;
    if (secs_sat == '0) secs_sat = SECS_W'(1);
    if (secs_sat > BLINK_SECS_MAX) secs_sat = BLINK_SECS_MAX;
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_interval <= FADE_INTERVAL_RST;
      blink_half    <= BLINK_HALF_RST;
      cur           <= '0;
      tgt           <= '0;
      fade_count    <= '0;
      fade_total    <= '0;
      fade_elapsed  <= '0;
      blink_limit   <= '0;
      blink_phase   <= '0;
      blink_on      <= 1'b0;
      blink_elapsed <= '0;
      perr          <= 1'b0;
      kind_q        <= KIND_TICK;
      result.valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_FADE_INTERVAL: fade_interval <= cfg.data[FIVL_W-1:0];
          REG_BLINK_HALF:    blink_half    <= cfg.data[HALF_W-1:0];
          default: ;
        endcase
      end

      if (cmd.cap) begin
        kind_q  <= kind;
        rgb_q   <= {blue_in, green_in, red_in};
        steps_q <= fade_steps;
        secs_q  <= blink_seconds;
        pidx_q  <= preset_index;
      end

      if (cmd.exec) begin
        perr <= (kind_q == KIND_PRESET) && (pidx_q > PRESET_LAST);
        unique case (kind_q)
          KIND_TICK: begin
            if (fade_due) begin
              fade_elapsed <= '0;
              fade_count   <= fade_count + 1'b1;
            end else if (fade_run) begin
              fade_elapsed <= fade_el_inc;
            end
          end
          KIND_SET: cur <= rgb_q;
          KIND_PRESET: begin
            if (pidx_q <= PRESET_LAST) cur <= preset_color(pidx_q);
          end
          KIND_FADE: begin
            tgt          <= rgb_q;
            fade_total   <= steps_sat;
            fade_count   <= '0;
            fade_elapsed <= '0;
          end
          KIND_BLINK: begin
            blink_limit   <= secs_sat;
            blink_phase   <= '0;
            blink_on      <= 1'b1;
            blink_elapsed <= '0;
            cur           <= {8'd0, 8'd0, LEVEL_MAX};
          end
          KIND_OFF: begin
            cur         <= '0;
            blink_limit <= '0;
          end
          default: ;
        endcase
      end

      if (cmd.mul) begin
        prod_neg <= prod[2*COLOR_W+1];
        prod_mag <= prod_abs[DIV_BITS-1:0];
      end

      if (cmd.apply) cur[cmd.chan] <= v_sat;

      if (cmd.blink && blink_limit != '0) begin
        if (blink_el_inc >= blink_lim) begin
          blink_elapsed <= '0;
          blink_phase   <= blink_phase_new;
          if (blink_phase_new >= blink_limit) begin
            blink_limit <= '0;
            blink_on    <= 1'b0;
            cur         <= '0;
          end else begin
            blink_on <= blink_on_new;
            cur      <= blink_on_new ? {8'd0, 8'd0, LEVEL_MAX} : '0;
          end
        end else begin
          blink_elapsed <= blink_el_inc;
        end
      end

      if (cmd.out_load) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.red_out      <= cur[0];
      result.green_out    <= cur[1];
      result.blue_out     <= cur[2];
      result.fade_active  <= fade_run;
      result.blink_active <= blink_limit != '0;
      result.preset_error <= perr;
    end
  end

  assign status.is_tick   = kind_q == KIND_TICK;
  assign status.fade_fire = fade_due;
  assign status.div_done  = div_done;
  assign status.out_free  = ~result.valid | result.ready;

endmodule

[src/rlfb_ctrl.sv]
// ----------------------------------------------------------------------------
// rlfb_ctrl
// Sequencer: command, fade step per channel through the divider, blink, result.
// ----------------------------------------------------------------------------
module rlfb_ctrl import rlfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MUL, S_DSTART, S_DWAIT, S_APPLY, S_BLINK, S_OUT
  } state_t;

  localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(NUM_CHAN - 1);

  state_t            state;
  logic [CHAN_W-1:0] chan;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd           = '0;
    cmd.chan      = chan;
    cmd.cap       = in_valid && state == S_IDLE;
    cmd.exec      = state == S_EXEC;
    cmd.mul       = state == S_MUL;
    cmd.div_start = state == S_DSTART;
    cmd.apply     = state == S_APPLY;
    cmd.blink     = state == S_BLINK;
    cmd.out_load  = state == S_OUT && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan  <= '0;
    end else begin
      unique case (state)
        S_IDLE:   if (in_valid) state <= S_EXEC;
        S_EXEC: begin
          chan <= '0;
          if (!status.is_tick)      state <= S_OUT;
          else if (status.fade_fire) state <= S_MUL;
          else                       state <= S_BLINK;
        end
        S_MUL:    state <= S_DSTART;
        S_DSTART: state <= S_DWAIT;
        S_DWAIT:  if (status.div_done) state <= S_APPLY;
        S_APPLY: begin
          if (chan == CHAN_LAST) begin
            state <= S_BLINK;
          end else begin
            chan  <= chan + 1'b1;
            state <= S_MUL;
          end
        end
        S_BLINK:  state <= S_OUT;
        S_OUT:    if (status.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule
